// ===== rtl/core/lsm_pkg.sv =====
`default_nettype none

package lsm_pkg;

    // stream item codes
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 3'd4;

    localparam int PAT_REGS  = 4;
    localparam int PAT_BYTES = 8 * PAT_REGS;
    localparam int PAT_SEL_W = $clog2(PAT_BYTES);
    localparam int PLEN_W    = 6;

    localparam int LINE_LEN_W = 12;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic                  is_stream_end;
        logic                  line_matched;
        logic [LINE_LEN_W-1:0] line_length;
        logic                  stream_found;
    } result_item_t;

    // up to two results per item, first one always used when second is
    typedef struct packed {
        logic         push_first;
        logic         push_second;
        result_item_t first;
        result_item_t second;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/line_substring_matcher.sv =====
// An accepted byte item is staged in the input register; when it leaves that register its
// results are written into the result queue, and result_valid follows the queue count.
// Throughput: one item per cycle; the input register waits while the 4-entry result
// queue has fewer than two free entries (end of stream may push a line and a summary).
// Reset: rst_n is asynchronous, active low; it clears the pattern registers, the line
// count, hit flags and the queue. No clearing pass is needed.
`default_nettype none

module line_substring_matcher
    import lsm_pkg::*;
#(
    parameter int MAX_LINE    = 4096,
    parameter int PATTERN_MAX = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // byte stream in
    input  wire logic                    data_valid,
    output logic                         data_ready,
    input  wire in_item_t                data_item,

    // line verdicts and stream summaries out
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output result_item_t                 result_item,

    // pattern registers, write only
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // pattern aligned to the byte window: lane i is compared against the
    // byte that arrived i bytes ago
    logic [PATTERN_MAX-1:0][7:0] lane_pat;
    logic [PATTERN_MAX-1:0]      lane_used;
    logic [LEN_W-1:0]            alen;
    logic                        room;
    push_t                       push;

    lsm_pattern #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lane_pat  (lane_pat),
        .lane_used (lane_used),
        .alen      (alen)
    );

    // input register, byte window, line counter and sticky hit flags;
    // the whole window compare is done in the cycle the item leaves the
    // input register
    lsm_line #(
        .MAX_LINE    (MAX_LINE),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_item  (data_item),
        .lane_pat   (lane_pat),
        .lane_used  (lane_used),
        .alen       (alen),
        .room       (room),
        .push       (push)
    );

    // result queue decouples output stalls from the byte stream
    lsm_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lsm_pattern.sv =====
`default_nettype none

module lsm_pattern
    import lsm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [CFG_DATA_W-1:0]             cfg_data,
    output logic [PATTERN_MAX-1:0][7:0]            lane_pat,
    output logic [PATTERN_MAX-1:0]                 lane_used,
    output logic [$clog2(PATTERN_MAX+1)-1:0]       alen
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_reg;
    logic [PLEN_W-1:0]                   plen_reg;
    logic [PAT_BYTES-1:0][7:0]           pat_bytes;

    // byte j of the pattern, zero past the register file
    function automatic logic [7:0] pick_byte(input logic [PAT_BYTES-1:0][7:0] pb,
                                             input int j);
        logic [PAT_SEL_W-1:0] sel;
        logic [7:0]           val;
        begin
            sel = PAT_SEL_W'(j);
            val = 8'd0;
            if (j >= 0 && j < PAT_BYTES)
                val = pb[sel];
            return val;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            plen_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAT_0_7:   pat_reg[0] <= cfg_data;
                CFG_PAT_8_15:  pat_reg[1] <= cfg_data;
                CFG_PAT_16_23: pat_reg[2] <= cfg_data;
                CFG_PAT_24_31: pat_reg[3] <= cfg_data;
                CFG_PAT_LEN:   plen_reg   <= cfg_data[PLEN_W-1:0];
                default:       ;
            endcase
        end
    end

    assign pat_bytes = pat_reg;

    // clamp to the window size
    always_comb
    begin
        if (32'(plen_reg) > 32'(PATTERN_MAX))
            alen = LEN_W'(PATTERN_MAX);
        else
            alen = LEN_W'(plen_reg);
    end

    // lane i holds the newest-minus-i byte; it must equal pattern[alen-1-i]
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            lane_used[i] = (i < int'(alen));
            lane_pat[i]  = pick_byte(pat_bytes, int'(alen) - 1 - i);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lsm_line.sv =====
`default_nettype none

module lsm_line
    import lsm_pkg::*;
#(
    parameter int MAX_LINE    = 4096,
    parameter int PATTERN_MAX = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              data_valid,
    output logic                                   data_ready,
    input  wire in_item_t                          data_item,
    input  wire logic [PATTERN_MAX-1:0][7:0]       lane_pat,
    input  wire logic [PATTERN_MAX-1:0]            lane_used,
    input  wire logic [$clog2(PATTERN_MAX+1)-1:0]  alen,
    input  wire logic                              room,
    output push_t                                  push
);

    localparam int CNT_W = $clog2(MAX_LINE);

    logic                          in_valid_reg, in_valid_next;
    in_item_t                      in_item_reg;
    logic [PATTERN_MAX-1:0][7:0]   window_reg, window_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          hit_reg, hit_next;
    logic                          any_reg, any_next;

    logic                          advance;
    logic                          is_nl;
    logic                          full;
    logic [CNT_W-1:0]              cnt_app;
    logic [PATTERN_MAX-1:0][7:0]   win_new;
    logic [PATTERN_MAX-1:0]        lane_ok;
    logic                          match;
    logic                          line_m;
    result_item_t                  line_res;
    result_item_t                  sum_res;

    // staged item moves on only if the queue can take two results
    assign advance       = in_valid_reg && room;
    assign data_ready    = !in_valid_reg || advance;
    assign in_valid_next = (data_valid && data_ready) ? 1'b1 :
                           (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            hit_reg      <= 1'b0;
            any_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
            hit_reg      <= hit_next;
            any_reg      <= any_next;
        end
    end

    // window contents past the line start are never compared
    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
            in_item_reg <= data_item;
        window_reg <= window_next;
    end

    assign is_nl   = (in_item_reg.data_byte == NEWLINE_BYTE);
    assign full    = (count_reg >= CNT_W'(MAX_LINE - 1));
    assign cnt_app = full ? CNT_W'(1) : count_reg + CNT_W'(1);

    always_comb
    begin
        win_new[0] = in_item_reg.data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
            win_new[i] = window_reg[i-1];
        for (int i = 0; i < PATTERN_MAX; i++)
            lane_ok[i] = !lane_used[i] || (win_new[i] == lane_pat[i]);
    end

    assign match = (alen != '0) && (32'(cnt_app) >= 32'(alen)) && (&lane_ok);
    assign line_m = hit_reg || (alen == '0);

    always_comb
    begin
        line_res.is_stream_end = 1'b0;
        line_res.line_matched  = line_m;
        line_res.line_length   = LINE_LEN_W'(count_reg);
        line_res.stream_found  = any_reg || line_m;

        sum_res.is_stream_end  = 1'b1;
        sum_res.line_matched   = 1'b0;
        sum_res.line_length    = '0;
        sum_res.stream_found   = any_reg || ((count_reg != '0) && line_m);
    end

    always_comb
    begin
        window_next      = window_reg;
        count_next       = count_reg;
        hit_next         = hit_reg;
        any_next         = any_reg;
        push.push_first  = 1'b0;
        push.push_second = 1'b0;
        push.first       = line_res;
        push.second      = sum_res;

        if (advance)
        begin
            if (in_item_reg.kind == KIND_DATA)
            begin
                if (is_nl || full)
                begin
                    push.push_first = 1'b1;
                    any_next        = any_reg || line_m;
                    count_next      = '0;
                    hit_next        = 1'b0;
                end
                if (!is_nl)
                begin
                    window_next = win_new;
                    count_next  = cnt_app;
                    hit_next    = (hit_reg && !full) || match;
                end
            end
            else
            begin
                push.push_first = 1'b1;
                if (count_reg != '0)
                    push.push_second = 1'b1;
                else
                    push.first = sum_res;
                count_next = '0;
                hit_next   = 1'b0;
                any_next   = 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_stream_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.kind == KIND_END)
        |=> (count_reg == '0) && !hit_reg && !any_reg)
        else $error("line state not cleared after end of stream");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_LINE - 1))
        else $error("line byte count past maximum line length");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lsm_out_fifo.sv =====
`default_nettype none

module lsm_out_fifo
    import lsm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire push_t        push,
    output logic              room,
    output logic              result_valid,
    input  wire logic         result_ready,
    output result_item_t      result_item
);

    result_item_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]       wr_reg, wr_next;
    logic [FIFO_PTR_W-1:0]       rd_reg, rd_next;
    logic [FIFO_CNT_W-1:0]       count_reg, count_next;
    logic                        pop;
    logic [FIFO_CNT_W-1:0]       n_push;

    assign room         = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result_item  = mem_reg[rd_reg];
    assign pop          = result_valid && result_ready;

    assign n_push     = FIFO_CNT_W'(push.push_first) + FIFO_CNT_W'(push.push_second);
    assign wr_next    = wr_reg + FIFO_PTR_W'(n_push);
    assign rd_next    = rd_reg + FIFO_PTR_W'(pop);
    assign count_next = count_reg + n_push - FIFO_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_first)
            mem_reg[wr_reg] <= push.first;
        if (push.push_second)
            mem_reg[wr_reg + FIFO_PTR_W'(1)] <= push.second;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.push_second |-> push.push_first)
        else $error("second result pushed without first");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.push_first |-> (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("results pushed without room for two");
`endif

endmodule

`default_nettype wire
